// File: hw/rtl/awbd_pkg.sv
// Shared types, constants and arithmetic helpers of the alpha weighted box downsampler.
package awbd_pkg;

  // Height limit, the widths that follow from it and the configuration port widths.
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_ALPHA_MODE = 2'd2
  } cfg_reg_e;

  // One source pixel.
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_pix_t;

  // One averaged output pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       level_end;
  } out_pix_t;

  // One pixel with its color weighted by alpha (or by one).
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [7:0]  a;
  } wpix_t;

  // Sum of two weighted pixels, as kept in the line buffer.
  typedef struct packed {
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
    logic [8:0]  a;
  } psum_t;

  localparam int unsigned PSUM_W = $bits(psum_t);

  // Position flags of one item within the level.
  typedef struct packed {
    logic used;
    logic odd_x;
    logic odd_y;
    logic last;
  } pos_t;

  // Floor of x / 255 for x up to 65025, by reciprocal and rounding offset.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Color times weight, where the weight is alpha or one.
  function automatic wpix_t weigh(input in_pix_t p, input logic mode);
    wpix_t w;
    if (mode) begin
      w.r = 16'(p.in_red) * 16'(p.in_alpha);
      w.g = 16'(p.in_green) * 16'(p.in_alpha);
      w.b = 16'(p.in_blue) * 16'(p.in_alpha);
    end else begin
      w.r = 16'(p.in_red);
      w.g = 16'(p.in_green);
      w.b = 16'(p.in_blue);
    end
    w.a = p.in_alpha;
    return w;
  endfunction

endpackage

// File: hw/rtl/alpha_weighted_box_downsample.sv
// Alpha weighted 2x2 box downsampler: produces one mipmap level from a row-major pixel stream.
// Throughput: one source item per cycle, sustained under no output stall.
// Path: an accepted item is loaded into the input stage, and a block result is loaded into the
// result register from there when the input stage can advance.
// Reset: position counters clear, width and height return to 256, alpha mode to off.
// The line buffer is not cleared; every entry is written on an even row before it is read.
module alpha_weighted_box_downsample #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  awbd_pkg::in_pix_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output awbd_pkg::out_pix_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [awbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [awbd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH / 2);
  localparam int unsigned DEPTH = MAX_WIDTH / 2;

  awbd_pkg::pos_t     pos;
  logic [AW-1:0]      idx;
  logic               alpha_mode;
  logic               in_acc, s1_adv, produce;

  logic               s1_valid_q;
  awbd_pkg::pos_t     s1_pos_q;
  logic [AW-1:0]      s1_idx_q;
  awbd_pkg::wpix_t    s1_px_q;
  awbd_pkg::wpix_t    pair_q;
  logic               out_valid_q;
  awbd_pkg::out_pix_t out_q;

  logic [awbd_pkg::PSUM_W-1:0] row_rdata;
  awbd_pkg::psum_t    pair_sum;
  awbd_pkg::out_pix_t avg_pix;

  // Handshakes: an item enters while the input stage can move on.
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign produce     = s1_pos_q.used && s1_pos_q.odd_x && s1_pos_q.odd_y;

  // Position tracking and configuration.
  awbd_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_acc),
    .pos_o       (pos),
    .idx_o       (idx),
    .alpha_mode_o(alpha_mode)
  );

  // Line buffer of even-row pair sums, read as an odd-row block completes.
  awbd_ram #(
    .WIDTH(awbd_pkg::PSUM_W),
    .DEPTH(DEPTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (s1_adv && s1_pos_q.used && s1_pos_q.odd_x && !s1_pos_q.odd_y),
    .waddr_i(s1_idx_q),
    .wdata_i(pair_sum),
    .re_i   (in_acc && pos.used && pos.odd_x && pos.odd_y),
    .raddr_i(idx),
    .rdata_o(row_rdata)
  );

  // Block sum and averaging.
  awbd_avg u_avg (
    .px_i        (s1_px_q),
    .pair_i      (pair_q),
    .row_i       (awbd_pkg::psum_t'(row_rdata)),
    .alpha_mode_i(alpha_mode),
    .last_i      (s1_pos_q.last),
    .pair_sum_o  (pair_sum),
    .pix_o       (avg_pix)
  );

  // Input stage holds the weighted pixel and its position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pos_q   <= '0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_pos_q   <= pos;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q <= idx;
      s1_px_q  <= awbd_pkg::weigh(in_data_i, alpha_mode);
    end
  end

  // The even column of a pair waits here for its odd partner.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else if (s1_adv && s1_pos_q.used && !s1_pos_q.odd_x) begin
      pair_q <= s1_px_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && produce) begin
      out_q <= avg_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/awbd_ram.sv
// Generic simple dual port RAM with one write port and one registered read port.
module awbd_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/awbd_pos.sv
// Configuration registers and the column and row position of the next source item.
module awbd_pos #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [awbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [awbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            step_i,
  output awbd_pkg::pos_t                  pos_o,
  output logic [$clog2(MAX_WIDTH/2)-1:0]  idx_o,
  output logic                            alpha_mode_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned AW  = $clog2(MAX_WIDTH / 2);
  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (CW > awbd_pkg::DIM_W) ? CW : awbd_pkg::DIM_W;
  localparam int unsigned HW  = awbd_pkg::DIM_W;
  localparam int unsigned YW  = awbd_pkg::ROW_W;

  logic [awbd_pkg::DIM_W-1:0] width_q, height_q;
  logic                       alpha_mode_q;
  logic [XW-1:0]              x_q;
  logic [YW-1:0]              y_q;

  logic [WW-1:0] w_raw, w_eff, used_w, x_ext;
  logic [HW-1:0] h_eff, used_h, y_ext;
  logic          in_used, last_col, last_row;

  // Clamp the dimensions and drop a trailing odd column or row.
  always_comb begin
    w_raw = WW'(width_q);
    if (w_raw < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_q < HW'(2)) begin
      h_eff = HW'(2);
    end else if (height_q > HW'(awbd_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(awbd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    used_w = {w_eff[WW-1:1], 1'b0};
    used_h = {h_eff[HW-1:1], 1'b0};
  end

  // Position flags of the item at the current counters.
  always_comb begin
    x_ext        = WW'(x_q);
    y_ext        = HW'(y_q);
    in_used      = (x_ext < used_w) && (y_ext < used_h);
    last_col     = (x_ext == w_eff - WW'(1));
    last_row     = (y_ext == h_eff - HW'(1));
    pos_o.used   = in_used;
    pos_o.odd_x  = x_q[0];
    pos_o.odd_y  = y_q[0];
    pos_o.last   = (x_ext == used_w - WW'(1)) && (y_ext == used_h - HW'(1));
  end

  assign idx_o        = x_q[AW:1];
  assign alpha_mode_o = alpha_mode_q;

  // Writes to the listed registers restart the level; accepted items advance the counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= awbd_pkg::DIM_W'(256);
      height_q     <= awbd_pkg::DIM_W'(256);
      alpha_mode_q <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
    end else if (cfg_valid_i) begin
      unique case (awbd_pkg::cfg_reg_e'(cfg_index_i))
        awbd_pkg::REG_SRC_WIDTH: begin
          width_q <= cfg_data_i;
          x_q     <= '0;
          y_q     <= '0;
        end
        awbd_pkg::REG_SRC_HEIGHT: begin
          height_q <= cfg_data_i;
          x_q      <= '0;
          y_q      <= '0;
        end
        awbd_pkg::REG_ALPHA_MODE: begin
          alpha_mode_q <= cfg_data_i[0];
          x_q          <= '0;
          y_q          <= '0;
        end
        default: begin
          x_q <= x_q;
        end
      endcase
    end else if (step_i) begin
      if (last_col) begin
        x_q <= '0;
        y_q <= last_row ? '0 : y_q + YW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/awbd_avg.sv
// Block sum and averaging of one 2x2 block into an output pixel.
module awbd_avg (
  input  awbd_pkg::wpix_t   px_i,
  input  awbd_pkg::wpix_t   pair_i,
  input  awbd_pkg::psum_t   row_i,
  input  logic              alpha_mode_i,
  input  logic              last_i,
  output awbd_pkg::psum_t   pair_sum_o,
  output awbd_pkg::out_pix_t pix_o
);

  awbd_pkg::psum_t ps;
  logic [17:0]     sr, sg, sb;
  logic [9:0]      sa;

  // Horizontal pair sum, then the full block sum with the even row.
  always_comb begin
    ps.r = 17'(pair_i.r) + 17'(px_i.r);
    ps.g = 17'(pair_i.g) + 17'(px_i.g);
    ps.b = 17'(pair_i.b) + 17'(px_i.b);
    ps.a = 9'(pair_i.a) + 9'(px_i.a);
    sr   = 18'(ps.r) + 18'(row_i.r);
    sg   = 18'(ps.g) + 18'(row_i.g);
    sb   = 18'(ps.b) + 18'(row_i.b);
    sa   = 10'(ps.a) + 10'(row_i.a);
  end

  assign pair_sum_o = ps;

  // Color: divide by 1020 as a quarter then a divide by 255, or by 4 alone; alpha is a quarter of the sum or 255.
  always_comb begin
    if (alpha_mode_i) begin
      pix_o.out_red   = awbd_pkg::div255(sr[17:2]);
      pix_o.out_green = awbd_pkg::div255(sg[17:2]);
      pix_o.out_blue  = awbd_pkg::div255(sb[17:2]);
      pix_o.out_alpha = sa[9:2];
    end else begin
      pix_o.out_red   = sr[9:2];
      pix_o.out_green = sg[9:2];
      pix_o.out_blue  = sb[9:2];
      pix_o.out_alpha = 8'hFF;
    end
    pix_o.level_end = last_i;
  end

endmodule

// File: tb/tb_alpha_weighted_box_downsample.sv
// Self-checking testbench of the alpha weighted 2x2 box downsampler.
`timescale 1ns / 1ps

module tb_alpha_weighted_box_downsample;

  // Geometry and timing of the run.
  localparam int unsigned SRC_MAX_W     = 4096;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 8;
  localparam int unsigned LONG_STALL    = 400;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned SEGMENT_ITEMS = 600;
  localparam int unsigned STALL_PHASE   = 2;
  localparam int unsigned WIDE_PHASE    = 5;
  localparam int unsigned WIDE_ITEMS    = 256;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  // A register index past the end of the list; the block ignores writes to it.
  localparam logic [awbd_pkg::CFG_IDX_W-1:0] REG_UNLISTED = 2'd3;

  // One row of the directed table: a register write or one source item.
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [awbd_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [awbd_pkg::CFG_DATA_W-1:0] reg_val;
    awbd_pkg::in_pix_t               pix;
    logic                            typed;
    awbd_pkg::out_pix_t              result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 33;

  // Directed table. Typed results are the ones that follow directly from the extremes.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Width below the range clamps to two; height and alpha mode keep their reset values.
    '{ROW_CFG, awbd_pkg::REG_SRC_WIDTH,  13'd0,    '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b1,
      '{8'd0, 8'd255, 8'd0, 8'd255, 1'b0}},
    // Half a block, then a register write restarts the level.
    '{ROW_PIX, '0, '0, '{8'd17, 8'd200, 8'd99, 8'd5}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd240, 8'd3, 8'd128, 8'd77}, 1'b0, '0},
    '{ROW_CFG, awbd_pkg::REG_SRC_HEIGHT, 13'd1,    '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd0, 8'd3, 8'd200}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd254, 8'd1, 8'd0, 8'd10}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
    // Alpha weighting with every sample at full scale.
    '{ROW_CFG, awbd_pkg::REG_ALPHA_MODE, 13'd1,    '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
    // A write past the register list in mid block must not restart the level.
    '{ROW_PIX, '0, '0, '{8'd90, 8'd180, 8'd45, 8'd128}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd3, 8'd250, 8'd77, 8'd64}, 1'b0, '0},
    '{ROW_CFG, REG_UNLISTED,             13'd8191, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd200, 8'd17, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd128, 8'd128, 8'd128, 8'd1}, 1'b0, '0},
    // Odd width and height: the trailing column and row give no result.
    '{ROW_CFG, awbd_pkg::REG_SRC_WIDTH,  13'd3,    '0, 1'b0, '0},
    '{ROW_CFG, awbd_pkg::REG_SRC_HEIGHT, 13'd3,    '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd10, 8'd20, 8'd30, 8'd40}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd50, 8'd60, 8'd70, 8'd80}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd90, 8'd100, 8'd110, 8'd120}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd130, 8'd140, 8'd150, 8'd160}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd1, 8'd2, 8'd3, 8'd4}, 1'b0, '0},
    '{ROW_PIX, '0, '0, '{8'd7, 8'd7, 8'd7, 8'd7}, 1'b0, '0}
  };

  // Clock, reset and the block's inputs, all known from time zero.
  logic                            clk_i     = 1'b0;
  logic                            rst_ni    = 1'b0;
  logic                            in_valid  = 1'b0;
  awbd_pkg::in_pix_t               in_data   = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [awbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [awbd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_ready_o;
  logic                            out_valid_o;
  awbd_pkg::out_pix_t              out_data_o;
  logic                            cfg_ready_o;

  // Settings and state of the sender and the receiver.
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 48;
  bit          stall_request = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned error_count   = 0;

  // Predicted block averages, oldest first.
  awbd_pkg::out_pix_t expected_blocks [$];

  // Shadow of the registers and the position within the level.
  typedef struct {
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned a;
  } chan_sums_t;

  int unsigned shadow_width  = 256;
  int unsigned shadow_height = 256;
  logic        shadow_alpha  = 1'b0;
  int unsigned col_pos       = 0;
  int unsigned row_pos       = 0;
  chan_sums_t  pair_sum      = '{default: 0};
  chan_sums_t  line_sums [SRC_MAX_W/2];

  alpha_weighted_box_downsample dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 250 MHz clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly small sizes, sometimes below the range or at or above the top of it.
  function automatic logic [awbd_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(19))
      0:       return awbd_pkg::CFG_DATA_W'($urandom_range(0, 1));
      1:       return awbd_pkg::CFG_DATA_W'($urandom_range(4096, 8191));
      2, 3, 4: return awbd_pkg::CFG_DATA_W'($urandom_range(10, 40));
      default: return awbd_pkg::CFG_DATA_W'($urandom_range(2, 9));
    endcase
  endfunction

  // Accumulates one source item into its 2x2 block and gives the average once complete.
  task automatic downsample_pixel(input awbd_pkg::in_pix_t p, output logic produced,
                                  output awbd_pkg::out_pix_t res);
    int unsigned w, h, used_w, used_h, weight, divisor, slot;
    chan_sums_t  px, s;
    w       = clamp_dim(shadow_width, SRC_MAX_W);
    h       = clamp_dim(shadow_height, awbd_pkg::MAX_HEIGHT);
    used_w  = w & ~32'd1;
    used_h  = h & ~32'd1;
    weight  = shadow_alpha ? int'(p.in_alpha) : 1;
    px.r    = weight * p.in_red;
    px.g    = weight * p.in_green;
    px.b    = weight * p.in_blue;
    px.a    = p.in_alpha;
    produced = 1'b0;
    res      = '0;
    if (col_pos < used_w && row_pos < used_h) begin
      if (col_pos[0] == 1'b0) begin
        pair_sum = px;
      end else begin
        slot = col_pos >> 1;
        s.r  = pair_sum.r + px.r;
        s.g  = pair_sum.g + px.g;
        s.b  = pair_sum.b + px.b;
        s.a  = pair_sum.a + px.a;
        if (row_pos[0] == 1'b0) begin
          line_sums[slot] = s;
        end else begin
          // The odd row completes the block with the even row's partial sum.
          divisor       = shadow_alpha ? 1020 : 4;
          s.r          += line_sums[slot].r;
          s.g          += line_sums[slot].g;
          s.b          += line_sums[slot].b;
          s.a          += line_sums[slot].a;
          res.out_red   = 8'(s.r / divisor);
          res.out_green = 8'(s.g / divisor);
          res.out_blue  = 8'(s.b / divisor);
          res.out_alpha = shadow_alpha ? 8'(s.a / 4) : 8'd255;
          res.level_end = (col_pos == used_w - 1) && (row_pos == used_h - 1);
          produced      = 1'b1;
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Writes one register and mirrors the write in the shadow; valid stays high.
  task automatic write_reg(input logic [awbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [awbd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      awbd_pkg::REG_SRC_WIDTH:  shadow_width  = val;
      awbd_pkg::REG_SRC_HEIGHT: shadow_height = val;
      awbd_pkg::REG_ALPHA_MODE: shadow_alpha  = val[0];
      default:                  return;
    endcase
    col_pos  = 0;
    row_pos  = 0;
    pair_sum = '{default: 0};
  endtask

  // Offers one source item after a random gap; a typed result replaces the predicted one.
  task automatic push_pixel(input awbd_pkg::in_pix_t p, input logic typed,
                            input awbd_pkg::out_pix_t typed_res);
    logic               produced;
    awbd_pkg::out_pix_t res;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    downsample_pixel(p, produced, res);
    if (typed) expected_blocks.push_back(typed_res);
    else if (produced) expected_blocks.push_back(res);
  endtask

  // Lets the block go idle: all results out, then the pipeline latency.
  task automatic drain();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: checks each accepted result, then picks ready for the next cycle.
  always @(posedge clk_i) begin
    awbd_pkg::out_pix_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $error("result %h arrived with no block pending", out_data_o);
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_data_o.out_red !== want.out_red) begin
          $error("out_red expected %0d got %0d", want.out_red, out_data_o.out_red);
          error_count++;
        end
        if (out_data_o.out_green !== want.out_green) begin
          $error("out_green expected %0d got %0d", want.out_green, out_data_o.out_green);
          error_count++;
        end
        if (out_data_o.out_blue !== want.out_blue) begin
          $error("out_blue expected %0d got %0d", want.out_blue, out_data_o.out_blue);
          error_count++;
        end
        if (out_data_o.out_alpha !== want.out_alpha) begin
          $error("out_alpha expected %0d got %0d", want.out_alpha, out_data_o.out_alpha);
          error_count++;
        end
        if (out_data_o.level_end !== want.level_end) begin
          $error("level_end expected %0d got %0d", want.level_end, out_data_o.level_end);
          error_count++;
        end
      end
    end
    if (stall_request) begin
      stall_left    = LONG_STALL;
      stall_request = 1'b0;
    end
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus: directed table, then random phases of register settings and images.
  initial begin
    int unsigned       phase_no;
    int unsigned       pixel_total;
    int unsigned       image_size;
    int unsigned       random_pixels;
    awbd_pkg::in_pix_t pix;
    phase_no      = 0;
    random_pixels = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        if (i > 0 && DIRECTED[i-1].kind == ROW_PIX) drain();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        push_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].result);
      end
    end

    while (random_pixels < RANDOM_ITEMS) begin
      phase_no++;
      // Sender idles lightly first, then the receiver, then neither.
      if (random_pixels >= 2 * SEGMENT_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_pixels >= SEGMENT_ITEMS) begin
        send_idle_pct = 48;
        recv_idle_pct = 16;
      end
      drain();
      if (phase_no == STALL_PHASE) begin
        // Tall narrow image while the receiver holds off, so the block backs up.
        write_reg(awbd_pkg::REG_SRC_WIDTH, 13'd8);
        write_reg(awbd_pkg::REG_SRC_HEIGHT, 13'd64);
        pixel_total   = 512;
        stall_request = 1'b1;
      end else if (phase_no == WIDE_PHASE) begin
        // Width above the range clamps to the widest line; the items stay on the even row.
        write_reg(awbd_pkg::REG_SRC_WIDTH, 13'd8191);
        write_reg(awbd_pkg::REG_SRC_HEIGHT, 13'd2);
        pixel_total = WIDE_ITEMS;
      end else begin
        if ($urandom_range(1)) write_reg(awbd_pkg::REG_SRC_WIDTH, pick_dim());
        if ($urandom_range(1)) write_reg(awbd_pkg::REG_SRC_HEIGHT, pick_dim());
        if ($urandom_range(2) == 0) begin
          write_reg(awbd_pkg::REG_ALPHA_MODE, awbd_pkg::CFG_DATA_W'($urandom));
        end
        if ($urandom_range(7) == 0) write_reg(REG_UNLISTED, awbd_pkg::CFG_DATA_W'($urandom));
        image_size = clamp_dim(shadow_width, SRC_MAX_W) *
                     clamp_dim(shadow_height, awbd_pkg::MAX_HEIGHT);
        // Mostly whole images; sometimes a broken one that the next phase picks up or restarts.
        if (image_size > 400 || $urandom_range(4) == 0) begin
          pixel_total = $urandom_range(1, 300);
        end else begin
          pixel_total = image_size * $urandom_range(1, 2);
        end
      end
      repeat (pixel_total) begin
        pix = awbd_pkg::in_pix_t'($urandom);
        if ($urandom_range(7) == 0) pix.in_alpha = $urandom_range(1) ? 8'd255 : 8'd0;
        if ($urandom_range(15) == 0) pix.in_red = $urandom_range(1) ? 8'd255 : 8'd0;
        push_pixel(pix, 1'b0, '0);
        random_pixels++;
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_alpha_weighted_box_downsample OK");
    end else begin
      $display("tb_alpha_weighted_box_downsample NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_alpha_weighted_box_downsample NOT OK");
    $finish;
  end

endmodule
